// ----- rtl/digit_image_feature_extractor_macros.svh -----
// Assertion helpers for the RTL
`ifndef DIGIT_IMAGE_FEATURE_EXTRACTOR_MACROS_SVH
`define DIGIT_IMAGE_FEATURE_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define DIFE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DIFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dife_pkg.sv -----
`default_nettype none

package dife_pkg;

   localparam int PIXEL_W   = 8;
   localparam int KIND_W    = 2;
   localparam int FIDX_W    = 10;
   localparam int FVAL_W    = 17;
   localparam int CSR_W     = 6;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_MAX_WIDTH  = 32;
   localparam int DEF_MAX_HEIGHT = 32;
   localparam int ZONE_GRID      = 4;
   localparam int MIN_SIZE       = 4;
   localparam logic [CSR_W-1:0] SIZE_RESET = 6'd28;

   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ZONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ROW   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_COL   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

endpackage

`default_nettype wire

// ----- rtl/dife_req_if.sv -----
`default_nettype none

interface dife_req_if;
   logic                            valid;
   logic                            ready;
   logic [dife_pkg::PIXEL_W-1:0]    pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/dife_rsp_if.sv -----
`default_nettype none

interface dife_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dife_pkg::KIND_W-1:0]     kind;
   logic [dife_pkg::FIDX_W-1:0]     feature_index;
   logic [dife_pkg::FVAL_W-1:0]     feature_value;
   logic                            last_of_item;

   modport source (output valid, output kind, output feature_index, output feature_value,
                   output last_of_item, input ready);
   modport sink   (input valid, input kind, input feature_index, input feature_value,
                   input last_of_item, output ready);
endinterface

`default_nettype wire

// ----- rtl/digit_image_feature_extractor.sv -----
`default_nettype none
`include "digit_image_feature_extractor_macros.svh"

// Zoning / projection feature extractor for one gray image per pass, pixels in raster
// order. Every pixel word gives its Q1.16 value (kind 0); a row's last pixel also gives
// the row mean (kind 2), then the four zone means when it closes a band of zone rows
// (kind 1), then all column means when it closes the image (kind 3). last_of_item marks
// the final result word of each pixel. A pixel with no mean behind it goes through a
// column-sum read, then emit. Each mean goes through one shared restoring divider, one
// quotient bit per cycle, in fetch, load, 17 divide steps and emit. req ready is high
// only between pixels. A configuration write restarts the image.
module digit_image_feature_extractor #(
   parameter int MAX_WIDTH  = dife_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dife_pkg::DEF_MAX_HEIGHT
) (
   input  wire                                clock,
   input  wire                                reset,
   dife_req_if.sink                           req_bus,
   dife_rsp_if.source                         rsp_bus,
   input  wire                                csr_write_en,
   input  wire [dife_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [dife_pkg::CSR_W-1:0]          csr_write_data
);

   localparam int ZG   = dife_pkg::ZONE_GRID;
   localparam int PW   = dife_pkg::PIXEL_W;
   localparam int FIW  = dife_pkg::FIDX_W;
   localparam int FVW  = dife_pkg::FVAL_W;
   localparam int CW   = dife_pkg::CSR_W;
   localparam int KW   = dife_pkg::KIND_W;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int CIW  = $clog2(MAX_WIDTH);
   localparam int RIW  = $clog2(MAX_HEIGHT);
   localparam int CSW  = $clog2(MAX_HEIGHT * 255 + 1);
   localparam int RSW  = $clog2(MAX_WIDTH * 255 + 1);
   localparam int ZSW  = $clog2((MAX_WIDTH / ZG) * (MAX_HEIGHT / ZG) * 255 + 1);
   localparam int ZCW  = (WW - 2) + (HW - 2);
   localparam int CNTW = (WW > HW) ? ((WW > ZCW) ? WW : ZCW) : ((HW > ZCW) ? HW : ZCW);
   localparam int REMW = CNTW + 9;
   localparam int PIW  = RIW + WW;
   localparam int QCW  = $clog2(FVW);
   localparam logic [QCW-1:0] QFIRST = QCW'(FVW - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PIX, ST_FETCH, ST_LOAD, ST_DIV, ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        cfg_w_ff, cfg_w_in, cfg_h_ff, cfg_h_in;
   logic [WW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;
   logic [WW-3:0]        zw;
   logic [HW-3:0]        zh;

   logic [CIW-1:0]       col_pos_ff, col_pos_in;
   logic [RIW-1:0]       row_pos_ff, row_pos_in;
   logic [WW-3:0]        zcol_ff, zcol_in;
   logic [2:0]           zc_ff, zc_in;
   logic [HW-3:0]        zrow_ff, zrow_in;
   logic [2:0]           band_ff, band_in;
   logic [RSW-1:0]       row_sum_ff, row_sum_in;
   logic [ZSW-1:0]       zone_sum_ff [ZG];
   logic [ZSW-1:0]       zone_sum_in [ZG];
   logic [MAX_WIDTH-1:0] col_vld_ff, col_vld_in;

   logic [CSW-1:0]       colmem [MAX_WIDTH];
   logic [CSW-1:0]       col_rd_ff;
   logic                 col_rd_vld_ff;
   logic [CIW-1:0]       rd_addr;
   logic                 mem_we;
   logic [CSW-1:0]       mem_wdata;

   logic [PW-1:0]        pix_ff, pix_in;
   logic [KW-1:0]        job_kind_ff, job_kind_in;
   logic [CIW-1:0]       job_idx_ff, job_idx_in;
   logic                 zone_due_ff, zone_due_in;
   logic                 last_row_ff, last_row_in;
   logic [1:0]           band_cur_ff, band_cur_in;
   logic [RIW-1:0]       row_cur_ff, row_cur_in;

   logic [REMW-1:0]      rem_ff, rem_in, den_ff, den_in, trial, div_sum, div_cnt;
   logic [FVW-1:0]       quo_ff, quo_in;
   logic [QCW-1:0]       qcnt_ff, qcnt_in;
   logic                 q_ge;
   logic [ZCW-1:0]       zone_cnt;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0]        rsp_kind_ff, rsp_kind_in;
   logic [FIW-1:0]       rsp_idx_ff, rsp_idx_in;
   logic [FVW-1:0]       rsp_val_ff, rsp_val_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_free;
   logic                 row_end;
   logic                 col_last;
   logic [PIW-1:0]       pix_idx;
   logic [FVW-1:0]       pix_val;

   always_comb begin
      if (cfg_w_ff < CW'(dife_pkg::MIN_SIZE)) begin
         w_eff = WW'(dife_pkg::MIN_SIZE);
      end else if (int'(cfg_w_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg_w_ff);
      end
      if (cfg_h_ff < CW'(dife_pkg::MIN_SIZE)) begin
         h_eff = HW'(dife_pkg::MIN_SIZE);
      end else if (int'(cfg_h_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(cfg_h_ff);
      end
   end

   assign zw        = w_eff[WW-1:2];
   assign zh        = h_eff[HW-1:2];
   assign zone_cnt  = ZCW'(zw) * ZCW'(zh);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign row_end   = (WW'(col_pos_ff) == w_eff - WW'(1));
   assign col_last  = (WW'(job_idx_ff) == w_eff - WW'(1));
   assign pix_idx   = PIW'(row_pos_ff) * PIW'(w_eff) + PIW'(col_pos_ff);
   // 255 * 257 = 65535, so p*65536/255 is 257p plus one at full scale
   assign pix_val   = {1'b0, pix_ff, pix_ff} + FVW'(pix_ff == {PW{1'b1}});
   // keep reading the pixel's column while its word waits for the output slot
   assign rd_addr   = (state_ff == ST_IDLE || state_ff == ST_PIX) ? col_pos_ff : job_idx_ff;

   // divider operands
   always_comb begin
      case (job_kind_ff)
         dife_pkg::KIND_ROW: begin
            div_sum = REMW'(row_sum_ff);
            div_cnt = REMW'(w_eff);
         end
         dife_pkg::KIND_ZONE: begin
            div_sum = REMW'(zone_sum_ff[job_idx_ff[1:0]]);
            div_cnt = REMW'(zone_cnt);
         end
         dife_pkg::KIND_COL: begin
            div_sum = col_rd_vld_ff ? REMW'(col_rd_ff) : '0;
            div_cnt = REMW'(h_eff);
         end
         default: begin
            div_sum = '0;
            div_cnt = REMW'(1);
         end
      endcase
   end

   // first step compares the sum itself, later steps shift in zeros
   assign trial = (qcnt_ff == QFIRST) ? rem_ff : {rem_ff[REMW-2:0], 1'b0};
   assign q_ge  = (trial >= den_ff);

   always_comb begin
      state_in     = state_ff;
      cfg_w_in     = cfg_w_ff;
      cfg_h_in     = cfg_h_ff;
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      zcol_in      = zcol_ff;
      zc_in        = zc_ff;
      zrow_in      = zrow_ff;
      band_in      = band_ff;
      row_sum_in   = row_sum_ff;
      zone_sum_in  = zone_sum_ff;
      col_vld_in   = col_vld_ff;
      pix_in       = pix_ff;
      job_kind_in  = job_kind_ff;
      job_idx_in   = job_idx_ff;
      zone_due_in  = zone_due_ff;
      last_row_in  = last_row_ff;
      band_cur_in  = band_cur_ff;
      row_cur_in   = row_cur_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      qcnt_in      = qcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_wdata    = (col_rd_vld_ff ? col_rd_ff : '0) + CSW'(pix_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               pix_in   = req_bus.pixel;
               state_in = ST_PIX;
            end
         end

         ST_PIX: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dife_pkg::KIND_PIXEL;
               rsp_idx_in   = FIW'(pix_idx);
               rsp_val_in   = pix_val;
               rsp_last_in  = !row_end;
               mem_we       = 1'b1;
               col_vld_in[col_pos_ff] = 1'b1;
               row_sum_in   = row_sum_ff + RSW'(pix_ff);
               if (zc_ff < 3'(ZG) && band_ff < 3'(ZG)) begin
                  zone_sum_in[zc_ff[1:0]] = zone_sum_ff[zc_ff[1:0]] + ZSW'(pix_ff);
               end
               if (row_end) begin
                  col_pos_in  = '0;
                  zcol_in     = '0;
                  zc_in       = '0;
                  row_cur_in  = row_pos_ff;
                  band_cur_in = band_ff[1:0];
                  last_row_in = (HW'(row_pos_ff) == h_eff - HW'(1));
                  zone_due_in = (band_ff < 3'(ZG)) && (zrow_ff == zh - (HW-2)'(1));
                  if (band_ff < 3'(ZG)) begin
                     if (zrow_ff == zh - (HW-2)'(1)) begin
                        zrow_in = '0;
                        band_in = band_ff + 3'd1;
                     end else begin
                        zrow_in = zrow_ff + (HW-2)'(1);
                     end
                  end
                  if (HW'(row_pos_ff) == h_eff - HW'(1)) begin
                     row_pos_in = '0;
                     zrow_in    = '0;
                     band_in    = '0;
                  end else begin
                     row_pos_in = row_pos_ff + RIW'(1);
                  end
                  job_kind_in = dife_pkg::KIND_ROW;
                  job_idx_in  = '0;
                  state_in    = ST_FETCH;
               end else begin
                  col_pos_in = col_pos_ff + CIW'(1);
                  if (zc_ff < 3'(ZG)) begin
                     if (zcol_ff == zw - (WW-2)'(1)) begin
                        zcol_in = '0;
                        zc_in   = zc_ff + 3'd1;
                     end else begin
                        zcol_in = zcol_ff + (WW-2)'(1);
                     end
                  end
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FETCH: begin
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            rem_in   = div_sum;
            den_in   = (div_cnt << 8) - div_cnt;
            quo_in   = '0;
            qcnt_in  = QFIRST;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            rem_in  = q_ge ? (trial - den_ff) : trial;
            quo_in  = {quo_ff[FVW-2:0], q_ge};
            qcnt_in = qcnt_ff - QCW'(1);
            if (qcnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = job_kind_ff;
               rsp_val_in   = quo_ff;
               case (job_kind_ff)
                  dife_pkg::KIND_ROW: begin
                     rsp_idx_in  = FIW'(row_cur_ff);
                     rsp_last_in = !zone_due_ff && !last_row_ff;
                     row_sum_in  = '0;
                     if (zone_due_ff) begin
                        job_kind_in = dife_pkg::KIND_ZONE;
                        job_idx_in  = '0;
                        state_in    = ST_FETCH;
                     end else if (last_row_ff) begin
                        job_kind_in = dife_pkg::KIND_COL;
                        job_idx_in  = '0;
                        state_in    = ST_FETCH;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  dife_pkg::KIND_ZONE: begin
                     rsp_idx_in  = FIW'({band_cur_ff, job_idx_ff[1:0]});
                     rsp_last_in = (job_idx_ff[1:0] == 2'(ZG - 1)) && !last_row_ff;
                     zone_sum_in[job_idx_ff[1:0]] = '0;
                     if (job_idx_ff[1:0] != 2'(ZG - 1)) begin
                        job_idx_in = job_idx_ff + CIW'(1);
                        state_in   = ST_FETCH;
                     end else if (last_row_ff) begin
                        job_kind_in = dife_pkg::KIND_COL;
                        job_idx_in  = '0;
                        state_in    = ST_FETCH;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  dife_pkg::KIND_COL: begin
                     rsp_idx_in  = FIW'(job_idx_ff);
                     rsp_last_in = col_last;
                     if (col_last) begin
                        // image done: column sums read back as zero from here on
                        col_vld_in = '0;
                        state_in   = ST_IDLE;
                     end else begin
                        job_idx_in = job_idx_ff + CIW'(1);
                        state_in   = ST_FETCH;
                     end
                  end
                  default: begin
                     rsp_idx_in  = '0;
                     rsp_last_in = 1'b1;
                     state_in    = ST_IDLE;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_en) begin
         case (csr_index)
            dife_pkg::CSR_IMAGE_WIDTH:  cfg_w_in = csr_write_data;
            dife_pkg::CSR_IMAGE_HEIGHT: cfg_h_in = csr_write_data;
            default: ;
         endcase
         col_pos_in  = '0;
         row_pos_in  = '0;
         zcol_in     = '0;
         zc_in       = '0;
         zrow_in     = '0;
         band_in     = '0;
         row_sum_in  = '0;
         col_vld_in  = '0;
         for (int i = 0; i < ZG; i++) begin
            zone_sum_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_w_ff     <= dife_pkg::SIZE_RESET;
         cfg_h_ff     <= dife_pkg::SIZE_RESET;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         zcol_ff      <= '0;
         zc_ff        <= '0;
         zrow_ff      <= '0;
         band_ff      <= '0;
         row_sum_ff   <= '0;
         col_vld_ff   <= '0;
         for (int i = 0; i < ZG; i++) begin
            zone_sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         zcol_ff      <= zcol_in;
         zc_ff        <= zc_in;
         zrow_ff      <= zrow_in;
         band_ff      <= band_in;
         row_sum_ff   <= row_sum_in;
         col_vld_ff   <= col_vld_in;
         zone_sum_ff  <= zone_sum_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      job_kind_ff <= job_kind_in;
      job_idx_ff  <= job_idx_in;
      zone_due_ff <= zone_due_in;
      last_row_ff <= last_row_in;
      band_cur_ff <= band_cur_in;
      row_cur_ff  <= row_cur_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      qcnt_ff     <= qcnt_in;
   end

   // column sum memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         colmem[col_pos_ff] <= mem_wdata;
      end
      col_rd_ff     <= colmem[rd_addr];
      col_rd_vld_ff <= col_vld_ff[rd_addr];
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_kind_ff;
   assign rsp_bus.feature_index = rsp_idx_ff;
   assign rsp_bus.feature_value = rsp_val_ff;
   assign rsp_bus.last_of_item  = rsp_last_ff;

   `DIFE_ASSERT_NOW(a_div_rem_bound, clock, reset, state_ff == ST_DIV, rem_ff <= den_ff,
      "divider remainder above divisor")
   `DIFE_ASSERT_NOW(a_mean_full_scale, clock, reset, state_ff == ST_EMIT,
      quo_ff <= FVW'(65536), "mean above full scale")
   `DIFE_ASSERT_NOW(a_pos_in_image, clock, reset, 1'b1,
      (WW'(col_pos_ff) < w_eff) && (HW'(row_pos_ff) < h_eff), "position outside image")
   `DIFE_ASSERT_NEXT(a_image_clear, clock, reset,
      state_ff == ST_EMIT && slot_free && job_kind_ff == dife_pkg::KIND_COL && col_last,
      col_vld_ff == '0 && state_ff == ST_IDLE, "column sums not cleared at image end")

endmodule

`default_nettype wire

// ----- test/digit_image_feature_extractor_tb.sv -----
`default_nettype none

module digit_image_feature_extractor_tb;

   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PIXELS = 80;
   localparam int IDLE_PERCENT  = 31;
   localparam int MAX_PRINTS    = 40;

   localparam int KIND_W    = dife_pkg::KIND_W;
   localparam int FIDX_W    = dife_pkg::FIDX_W;
   localparam int FVAL_W    = dife_pkg::FVAL_W;
   localparam int PIXEL_W   = dife_pkg::PIXEL_W;
   localparam int CSR_W     = dife_pkg::CSR_W;
   localparam int CSR_IDX_W = dife_pkg::CSR_IDX_W;
   localparam int ZONE_GRID = dife_pkg::ZONE_GRID;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [FIDX_W-1:0] index;
      logic [FVAL_W-1:0] value;
      logic              last;
   } feature_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_write_data;

   dife_req_if req_bus ();
   dife_rsp_if rsp_bus ();

   digit_image_feature_extractor dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [CSR_W-1:0] cfg_width;
   logic [CSR_W-1:0] cfg_height;
   int unsigned col_sum [dife_pkg::DEF_MAX_WIDTH];
   int unsigned row_acc;
   int unsigned zone_acc [ZONE_GRID];
   int unsigned col_pos;
   int unsigned row_pos;

   feature_word_type pending_features[$];
   int mismatch_count = 0;
   int stall_count = 0;
   int hold_left = 0;
   bit steady_flow = 1'b0;

   function automatic void clear_image();
      foreach (col_sum[i]) col_sum[i] = 0;
      foreach (zone_acc[i]) zone_acc[i] = 0;
      row_acc = 0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   function automatic int unsigned effective_size(logic [CSR_W-1:0] v, int unsigned hi);
      if (v < dife_pkg::MIN_SIZE) return dife_pkg::MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [FVAL_W-1:0] q16_mean(int unsigned sum, int unsigned count);
      longint unsigned num;
      longint unsigned den;
      num = longint'(sum) * 65536;
      den = longint'(count) * 255;
      return FVAL_W'(num / den);
   endfunction

   function automatic feature_word_type make_word(logic [KIND_W-1:0] kind, int unsigned idx,
                                                  logic [FVAL_W-1:0] value);
      feature_word_type fw;
      fw.kind  = kind;
      fw.index = FIDX_W'(idx);
      fw.value = value;
      fw.last  = 1'b0;
      return fw;
   endfunction

   function automatic void predict_features(logic [PIXEL_W-1:0] p);
      int unsigned w, h, zw, zh, c, r, band, j;
      feature_word_type burst[$];
      w  = effective_size(cfg_width, dife_pkg::DEF_MAX_WIDTH);
      h  = effective_size(cfg_height, dife_pkg::DEF_MAX_HEIGHT);
      zw = w / ZONE_GRID;
      zh = h / ZONE_GRID;
      c  = col_pos;
      r  = row_pos;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      burst = {burst, make_word(dife_pkg::KIND_PIXEL, r * w + c, q16_mean(p, 1))};
      col_sum[c] += p;
      row_acc += p;
      // pixels right of or below the zone grid only feed row/column means
      if (c < ZONE_GRID * zw && r < ZONE_GRID * zh) zone_acc[c / zw] += p;
      if (c == w - 1) begin
         burst = {burst, make_word(dife_pkg::KIND_ROW, r, q16_mean(row_acc, w))};
         row_acc = 0;
         if (r < ZONE_GRID * zh && ((r + 1) % zh) == 0) begin
            band = r / zh;
            for (j = 0; j < ZONE_GRID; j++) begin
               burst = {burst, make_word(dife_pkg::KIND_ZONE, band * ZONE_GRID + j,
                                         q16_mean(zone_acc[j], zw * zh))};
               zone_acc[j] = 0;
            end
         end
         if (r == h - 1) begin
            for (j = 0; j < w; j++)
               burst = {burst, make_word(dife_pkg::KIND_COL, j, q16_mean(col_sum[j], h))};
            clear_image();
         end else begin
            col_pos = 0;
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      burst[burst.size() - 1].last = 1'b1;
      pending_features = {pending_features, burst};
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // monitor: model update and result check
   always @(posedge clock) begin
      feature_word_type want;
      if (reset) begin
         cfg_width = dife_pkg::SIZE_RESET;
         cfg_height = dife_pkg::SIZE_RESET;
         clear_image();
         pending_features.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == dife_pkg::CSR_IMAGE_WIDTH) cfg_width = csr_write_data;
            else cfg_height = csr_write_data;
            clear_image();
         end
         if (req_bus.valid && req_bus.ready) predict_features(req_bus.pixel);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_features.size() == 0) begin
               report_mismatch("unexpected word, index", rsp_bus.feature_index, -1);
            end else begin
               want = pending_features.pop_front();
               if (rsp_bus.kind !== want.kind)
                  report_mismatch("kind", rsp_bus.kind, want.kind);
               if (rsp_bus.feature_index !== want.index)
                  report_mismatch("feature_index", rsp_bus.feature_index, want.index);
               if (rsp_bus.feature_value !== want.value)
                  report_mismatch("feature_value", rsp_bus.feature_value, want.value);
               if (rsp_bus.last_of_item !== want.last)
                  report_mismatch("last_of_item", rsp_bus.last_of_item, want.last);
            end
         end
      end
   end

   // watchdog: cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("digit_image_feature_extractor regression: fail");
         $finish;
      end
   end

   // result side ready, with random idles and the long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else begin
            rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // entered right after a rising edge; returns at the edge that accepts the word
   task automatic send_pixel(input logic [PIXEL_W-1:0] p);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         req_bus.pixel <= PIXEL_W'($urandom);
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= p;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_features.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] random_size();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) return CSR_W'($urandom_range(4, 8));
      if (pick < 75) return CSR_W'($urandom_range(9, 16));
      if (pick < 85) return CSR_W'($urandom_range(0, 3));
      if (pick < 93) return CSR_W'($urandom_range(17, 32));
      return CSR_W'($urandom_range(33, 63));
   endfunction

   // a few words under the reset size, left unfinished
   task automatic test_reset_size();
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'hAA);
      send_pixel(8'h55);
      wait_idle();
   endtask

   // sizes below the minimum clamp to 4x4; the write also drops the open image
   task automatic test_min_image();
      logic [PIXEL_W-1:0] pattern [16];
      pattern = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
                  8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'hFF};
      write_register(dife_pkg::CSR_IMAGE_WIDTH, 6'd0);
      write_register(dife_pkg::CSR_IMAGE_HEIGHT, 6'd3);
      foreach (pattern[i]) send_pixel(pattern[i]);
      wait_idle();
   endtask

   // widest and tallest images, sizes above the maximum clamp; no idling here
   task automatic test_large_sizes();
      steady_flow = 1'b1;
      write_register(dife_pkg::CSR_IMAGE_WIDTH, 6'd63);
      write_register(dife_pkg::CSR_IMAGE_HEIGHT, 6'd4);
      repeat (32 * 4) send_pixel(random_pixel());
      wait_idle();
      write_register(dife_pkg::CSR_IMAGE_WIDTH, 6'd4);
      write_register(dife_pkg::CSR_IMAGE_HEIGHT, 6'd32);
      repeat (4 * 32) send_pixel(random_pixel());
      wait_idle();
      steady_flow = 1'b0;
   endtask

   // result side holds off while pixels keep coming, so the block backs up
   task automatic test_backpressure();
      write_register(dife_pkg::CSR_IMAGE_WIDTH, 6'd8);
      write_register(dife_pkg::CSR_IMAGE_HEIGHT, 6'd4);
      hold_left <= HOLD_CYCLES;
      repeat (40) send_pixel(random_pixel());
      wait_idle();
   endtask

   task automatic test_random_images();
      int unsigned sent, area, npix;
      logic [CSR_W-1:0] w_val, h_val;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         w_val = random_size();
         h_val = random_size();
         while (effective_size(w_val, dife_pkg::DEF_MAX_WIDTH) *
                effective_size(h_val, dife_pkg::DEF_MAX_HEIGHT) > 144)
            h_val = CSR_W'($urandom_range(0, 4));
         area = effective_size(w_val, dife_pkg::DEF_MAX_WIDTH) *
                effective_size(h_val, dife_pkg::DEF_MAX_HEIGHT);
         if ($urandom_range(1)) begin
            write_register(dife_pkg::CSR_IMAGE_WIDTH, w_val);
            write_register(dife_pkg::CSR_IMAGE_HEIGHT, h_val);
         end else begin
            write_register(dife_pkg::CSR_IMAGE_HEIGHT, h_val);
            write_register(dife_pkg::CSR_IMAGE_WIDTH, w_val);
         end
         // a partial image is cut short by the next register write
         if ($urandom_range(3) == 0) npix = $urandom_range(1, area - 1);
         else npix = area * $urandom_range(1, 2);
         repeat (npix) begin
            send_pixel(random_pixel());
            sent++;
         end
         wait_idle();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= dife_pkg::CSR_IMAGE_WIDTH;
      csr_write_data <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.pixel  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_size();
      test_min_image();
      test_large_sizes();
      test_backpressure();
      test_random_images();
      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("digit_image_feature_extractor regression: pass");
      else
         $display("digit_image_feature_extractor regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
